FILE: rtl/complex_arithmetic_unit_defines.svh
// Assertion macros shared by the complex arithmetic unit RTL.
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define CAU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("complex_arithmetic_unit: check failed");
`define CAU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("complex_arithmetic_unit: check failed");
`else
`define CAU_ASSERT_IMP(lbl, ante, cons)
`define CAU_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/cau_pkg.sv
// Types, codes and helper functions of the complex arithmetic unit.
package cau_pkg;

  localparam int QBITS = 33;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } cau_op_t;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
  } cau_in_t;

  typedef struct packed {
    logic signed [31:0] res_re;
    logic signed [31:0] res_im;
    logic               overflow;
    logic               div_zero;
  } cau_out_t;

  // One result part on its way down the divider chain.
  typedef struct packed {
    logic             neg;
    logic             big;
    logic [63:0]      rem;
    logic [QBITS-1:0] low;
    logic [QBITS-1:0] q;
  } cau_lane_t;

  // Everything one cell hands to its neighbor.
  typedef struct packed {
    logic        div;
    logic        dz;
    logic [63:0] d;
    cau_lane_t   re;
    cau_lane_t   im;
  } cau_cell_t;

  // One restoring division step: shift in the next dividend bit, subtract if it fits.
  function automatic cau_lane_t cau_div_step(cau_lane_t lane, logic [63:0] d);
    logic [64:0] rem2;
    logic        ge;
    cau_lane_t   r;
    rem2   = {lane.rem, lane.low[QBITS-1]};
    ge     = (rem2 >= {1'b0, d});
    r      = lane;
    r.rem  = ge ? 64'(rem2 - {1'b0, d}) : rem2[63:0];
    r.low  = {lane.low[QBITS-2:0], 1'b0};
    r.q    = {lane.q[QBITS-2:0], ge};
    return r;
  endfunction

  // Saturate a sign and magnitude to 32 bits; the top bit of the result is the overflow flag.
  function automatic logic [32:0] cau_sat(cau_lane_t lane);
    logic [32:0] r;
    if (lane.neg) begin
      if (lane.big || (lane.q > 33'h080000000)) begin
        r = {1'b1, 32'h80000000};
      end else begin
        r = {1'b0, 32'(-lane.q[31:0])};
      end
    end else begin
      if (lane.big || (lane.q[32:31] != 2'b00)) begin
        r = {1'b1, 32'h7FFFFFFF};
      end else begin
        r = {1'b0, lane.q[31:0]};
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/complex_arithmetic_unit.sv
// Complex arithmetic unit: add, subtract, multiply and divide on Q16.16 operands.
// The path from the accepting edge to the done strobe runs through five front stages
// (input, products, sums, magnitude, divider setup), 33 divider cells and one output register.
// Throughput is one item per cycle; busy stays low, as every stage advances each cycle.
// Synchronous active-high reset clears the valid bits; the receiver cannot stall.
`include "complex_arithmetic_unit_defines.svh"
module complex_arithmetic_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  cau_pkg::cau_in_t operands,
  output logic             done,
  output cau_pkg::cau_out_t result
);
  import cau_pkg::*;

  localparam int NW      = 64 + FRAC_BITS;
  localparam int LATENCY = 5 + QBITS + 1;

  // Stage valid bits.
  logic v1, v2, v3, v4, v5;

  // Stage 1: operands and divisor magnitudes.
  logic [1:0]         op1;
  logic signed [31:0] ar1, ai1, br1, bi1;
  logic [31:0]        bmr1, bmi1;

  // Stage 2: products and squares.
  logic [1:0]         op2;
  logic signed [31:0] ar2, ai2, br2, bi2;
  logic signed [63:0] p_rr, p_ii, p_ri, p_ir;
  logic [63:0]        sq_r, sq_i;

  // Stage 3: exact sums and divisor.
  logic [1:0]         op3;
  logic signed [65:0] num_re, num_im;
  logic [63:0]        d3;

  // Stage 4: sign and magnitude.
  logic [65:0] abs_re, abs_im;
  logic [1:0]  op4;
  logic        neg_re4, neg_im4;
  logic [63:0] mag_re4, mag_im4;
  logic [63:0] d4;

  // Stage 5 and the chain.
  logic      v_chain [QBITS+1];
  cau_cell_t d_chain [QBITS+1];
  cau_cell_t setup_next;

  logic [32:0] sat_re, sat_im;

  // Result parts sitting at a saturation bound.
  logic re_at_bound, im_at_bound;

  assign busy = 1'b0;

  // Valid pipeline of the front stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= start && !busy;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // Stage 1: register the item and take the divisor magnitudes.
  always_ff @(posedge clk) begin
    op1  <= operands.op;
    ar1  <= operands.a_re;
    ai1  <= operands.a_im;
    br1  <= operands.b_re;
    bi1  <= operands.b_im;
    bmr1 <= operands.b_re[31] ? 32'(-operands.b_re) : operands.b_re;
    bmi1 <= operands.b_im[31] ? 32'(-operands.b_im) : operands.b_im;
  end

  // Stage 2: the four cross products and the two squares.
  always_ff @(posedge clk) begin
    op2  <= op1;
    ar2  <= ar1;
    ai2  <= ai1;
    br2  <= br1;
    bi2  <= bi1;
    p_rr <= ar1 * br1;
    p_ii <= ai1 * bi1;
    p_ri <= ar1 * bi1;
    p_ir <= ai1 * br1;
    sq_r <= 64'(bmr1) * 64'(bmr1);
    sq_i <= 64'(bmi1) * 64'(bmi1);
  end

  // Stage 3: numerators for the selected operation.
  always_ff @(posedge clk) begin
    op3 <= op2;
    d3  <= sq_r + sq_i;
    case (op2)
      OP_ADD: begin
        num_re <= 66'(ar2) + 66'(br2);
        num_im <= 66'(ai2) + 66'(bi2);
      end
      OP_SUB: begin
        num_re <= 66'(ar2) - 66'(br2);
        num_im <= 66'(ai2) - 66'(bi2);
      end
      OP_MUL: begin
        num_re <= 66'(p_rr) - 66'(p_ii);
        num_im <= 66'(p_ri) + 66'(p_ir);
      end
      default: begin
        num_re <= 66'(p_rr) + 66'(p_ii);
        num_im <= 66'(p_ir) - 66'(p_ri);
      end
    endcase
  end

  // Absolute values of the numerators.
  assign abs_re = num_re[65] ? 66'(-num_re) : num_re;
  assign abs_im = num_im[65] ? 66'(-num_im) : num_im;

  // Stage 4: magnitudes; a product is truncated toward zero here.
  always_ff @(posedge clk) begin
    op4     <= op3;
    d4      <= d3;
    neg_re4 <= num_re[65];
    neg_im4 <= num_im[65];
    if (op3 == OP_MUL) begin
      mag_re4 <= abs_re[63:0] >> FRAC_BITS;
      mag_im4 <= abs_im[63:0] >> FRAC_BITS;
    end else begin
      mag_re4 <= abs_re[63:0];
      mag_im4 <= abs_im[63:0];
    end
  end

  // Stage 5: divider setup; a quotient of 2^33 or more is marked big at once.
  always_comb begin
    logic [NW-1:0] n_re, n_im, h_re, h_im, d_wide;
    n_re   = NW'(mag_re4) << FRAC_BITS;
    n_im   = NW'(mag_im4) << FRAC_BITS;
    h_re   = n_re >> QBITS;
    h_im   = n_im >> QBITS;
    d_wide = NW'(d4);
    setup_next        = '0;
    setup_next.d      = d4;
    setup_next.div    = (op4 == OP_DIV);
    setup_next.dz     = (op4 == OP_DIV) && (d4 == 64'd0);
    setup_next.re.neg = neg_re4;
    setup_next.im.neg = neg_im4;
    if (op4 == OP_DIV) begin
      if (d4 != 64'd0) begin
        setup_next.re.big = (h_re >= d_wide);
        setup_next.im.big = (h_im >= d_wide);
        setup_next.re.rem = setup_next.re.big ? 64'd0 : h_re[63:0];
        setup_next.im.rem = setup_next.im.big ? 64'd0 : h_im[63:0];
        setup_next.re.low = n_re[QBITS-1:0];
        setup_next.im.low = n_im[QBITS-1:0];
      end
    end else begin
      setup_next.re.q   = mag_re4[QBITS-1:0];
      setup_next.im.q   = mag_im4[QBITS-1:0];
      setup_next.re.big = |mag_re4[63:QBITS];
      setup_next.im.big = |mag_im4[63:QBITS];
    end
  end

  always_ff @(posedge clk) begin
    d_chain[0] <= setup_next;
  end

  assign v_chain[0] = v5;

  // Chain of divider cells, one quotient bit each.
  for (genvar g = 0; g < QBITS; g++) begin : g_cell
    cau_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (v_chain[g]),
      .data_in   (d_chain[g]),
      .valid_out (v_chain[g+1]),
      .data_out  (d_chain[g+1])
    );
  end

  // Output register with saturation and flags.
  assign sat_re = cau_sat(d_chain[QBITS].re);
  assign sat_im = cau_sat(d_chain[QBITS].im);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v_chain[QBITS];
    end
  end

  always_ff @(posedge clk) begin
    if (d_chain[QBITS].dz) begin
      result.res_re   <= '0;
      result.res_im   <= '0;
      result.overflow <= 1'b0;
      result.div_zero <= 1'b1;
    end else begin
      result.res_re   <= sat_re[31:0];
      result.res_im   <= sat_im[31:0];
      result.overflow <= sat_re[32] || sat_im[32];
      result.div_zero <= 1'b0;
    end
  end

  // A saturated part sits at one of the two bounds.
  assign re_at_bound = (result.res_re == 32'sh7FFFFFFF) || (result.res_re == 32'sh80000000);
  assign im_at_bound = (result.res_im == 32'sh7FFFFFFF) || (result.res_im == 32'sh80000000);

  `CAU_ASSERT_IMP(a_latency, start && !busy, ##(LATENCY) done)
  `CAU_ASSERT_IMP(a_flags_excl, done, !(result.overflow && result.div_zero))
  `CAU_ASSERT_IMP(a_dz_zero, done && result.div_zero, ~|{result.res_re, result.res_im})
  `CAU_ASSERT_IMP(a_ovf_sat, done && result.overflow, re_at_bound || im_at_bound)
  `CAU_ASSERT_NXT(a_chain_done, v_chain[QBITS], done)

endmodule

FILE: rtl/cau_cell.sv
// One cell of the divider chain: one quotient bit for both result parts.
module cau_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               valid_in,
  input  cau_pkg::cau_cell_t data_in,
  output logic               valid_out,
  output cau_pkg::cau_cell_t data_out
);
  import cau_pkg::*;

  logic      active;
  cau_cell_t data_next;

  // Only a divide with a nonzero divisor steps; other items pass unchanged.
  assign active = data_in.div && !data_in.dz;

  always_comb begin
    data_next = data_in;
    if (active) begin
      data_next.re = cau_div_step(data_in.re, data_in.d);
      data_next.im = cau_div_step(data_in.im, data_in.d);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    data_out <= data_next;
  end

endmodule
